// ===== hw/rtl/prq_pkg.sv =====
// Package for the packet ring queue with source tally.
// Holds command, result and sequencer types and fixed codes; no dependencies.
package prq_pkg;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_EMIT = 2'd1;
    localparam logic [1:0] FUNC_SEND = 2'd2;
    localparam logic [1:0] FUNC_READ = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DROP  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] ACTION_NONE       = 2'd0;
    localparam logic [1:0] ACTION_SOFT_RESET = 2'd1;
    localparam logic [1:0] ACTION_HARD_RESET = 2'd2;
    localparam logic [1:0] ACTION_DUTY_CYCLE = 2'd3;

    localparam logic [7:0] FAIL_SOFT_LEVEL = 8'd20;
    localparam logic [7:0] FAIL_HARD_LEVEL = 8'd40;
    localparam logic [7:0] FAIL_DUTY_LEVEL = 8'd50;
    localparam logic [7:0] FAIL_MAX        = 8'd255;
    localparam logic [7:0] NO_SOURCE       = 8'h0;

    localparam int NODE_BYTES = 6;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_EMIT,
        CMD_SEND,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] source_addr;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       send_ok;
        logic [2:0] entry_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
        logic [4:0] occupancy;
        logic [1:0] fail_action;
        logic [7:0] entry_source;
        logic [7:0] entry_count;
        logic [3:0] modules_seen;
        logic [7:0] seq_number;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC,
        ST_ADDR,
        ST_READ,
        ST_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/packet_ring_queue_with_source_tally_unit.sv =====
// Top level of the packet ring queue with source tally.
// Instantiates prq_front and prq_back; depends on prq_pkg.
//
// channel   handshake                  payload
// input     push / full                func source_addr data_byte byte_valid
//                                      last_byte send_ok entry_index
// result    empty / pop                out_byte out_last status occupancy
//                                      fail_action entry_source entry_count
//                                      modules_seen seq_number
// config    cfg_valid / cfg_ready      cfg_data (node address)
//
// Push, send and tally-read items are done in the back end's idle state; an
// emit runs ST_SRC, ST_ADDR per node byte, then ST_READ for the registered
// store read ahead of each stored byte and ST_OUT. Items queue two deep in
// front and results two deep behind, so either side stalls alone. Reset
// clears pointers, counters and the tally table at once; stores need no clearing.
module packet_ring_queue_with_source_tally_unit #(
    parameter int QUEUE_SLOTS = 32,
    parameter int ENTRY_BYTES = 50,
    parameter int TALLY_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [7:0]  source_addr,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_byte,
    input  logic        send_ok,
    input  logic [2:0]  entry_index,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic [1:0]  status,
    output logic [4:0]  occupancy,
    output logic [1:0]  fail_action,
    output logic [7:0]  entry_source,
    output logic [7:0]  entry_count,
    output logic [3:0]  modules_seen,
    output logic [7:0]  seq_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data
);
    import prq_pkg::*;

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_take;
    result_t res;

    assign cfg_ready = 1'b1;

    prq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .source_addr (source_addr),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last_byte   (last_byte),
        .send_ok     (send_ok),
        .entry_index (entry_index),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    prq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .ENTRY_BYTES (ENTRY_BYTES),
        .TALLY_SLOTS (TALLY_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign out_byte     = res.out_byte;
    assign out_last     = res.out_last;
    assign status       = res.status;
    assign occupancy    = res.occupancy;
    assign fail_action  = res.fail_action;
    assign entry_source = res.entry_source;
    assign entry_count  = res.entry_count;
    assign modules_seen = res.modules_seen;
    assign seq_number   = res.seq_number;

endmodule

// ===== hw/rtl/prq_front.sv =====
// Front end: accepts input items, classifies them and holds them in a
// two-entry command queue. Depends on prq_pkg.
module prq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    func,
    input  logic [7:0]    source_addr,
    input  logic [7:0]    data_byte,
    input  logic          byte_valid,
    input  logic          last_byte,
    input  logic          send_ok,
    input  logic [2:0]    entry_index,
    output logic          cmd_valid,
    output prq_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import prq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       accept;

    always_comb
    begin
        in_cmd = '0;
        unique case (func)
            FUNC_PUSH: in_cmd.kind = CMD_PUSH;
            FUNC_EMIT: in_cmd.kind = CMD_EMIT;
            FUNC_SEND: in_cmd.kind = CMD_SEND;
            default:   in_cmd.kind = CMD_READ;
        endcase
        in_cmd.source_addr = source_addr;
        in_cmd.data_byte   = data_byte;
        in_cmd.byte_valid  = byte_valid;
        in_cmd.last_byte   = last_byte;
        in_cmd.send_ok     = send_ok;
        in_cmd.entry_index = entry_index;
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_reg <= !wr_reg;
            end
            if (cmd_take)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(cmd_take);
        end
    end

endmodule

// ===== hw/rtl/prq_back.sv =====
// Back end: packet store, tally table, failure count, emit sequencer and
// the two-entry result queue. Depends on prq_pkg.
module prq_back #(
    parameter int QUEUE_SLOTS = 32,
    parameter int ENTRY_BYTES = 50,
    parameter int TALLY_SLOTS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  prq_pkg::cmd_t    cmd,
    output logic             cmd_take,
    input  logic             cfg_we,
    input  logic [47:0]      cfg_data,
    output logic             empty,
    input  logic             pop,
    output prq_pkg::result_t res
);
    import prq_pkg::*;

    localparam int PW   = $clog2(QUEUE_SLOTS);
    localparam int PLEN = ENTRY_BYTES - 1;
    localparam int LW   = $clog2(ENTRY_BYTES + 1);
    localparam int AW   = $clog2(QUEUE_SLOTS * PLEN);
    localparam int TW   = (TALLY_SLOTS > 1) ? $clog2(TALLY_SLOTS) : 1;
    localparam int CW   = $clog2(TALLY_SLOTS + 1);

    logic [47:0]   node_reg;
    logic [7:0]    pay_mem [QUEUE_SLOTS * PLEN];
    logic [7:0]    src_mem [QUEUE_SLOTS];
    logic [LW-1:0] len_mem [QUEUE_SLOTS];
    logic [7:0]    pay_q;
    logic [7:0]    src_q;
    logic [LW-1:0] len_q;

    back_state_t   state_reg, state_next;
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic          in_msg_reg, in_msg_next, drop_reg, drop_next;
    logic [LW-1:0] pc_reg, pc_next;
    logic [7:0]    seq_reg, seq_next, fail_reg, fail_next;
    logic [7:0]    tsrc_reg [TALLY_SLOTS];
    logic [7:0]    tsrc_next [TALLY_SLOTS];
    logic [7:0]    tcnt_reg [TALLY_SLOTS];
    logic [7:0]    tcnt_next [TALLY_SLOTS];
    logic [CW-1:0] total_reg, total_next;
    logic [LW-1:0] k_reg, k_next, len_reg, len_next;
    logic [2:0]    nb_reg, nb_next;

    logic          pay_we, src_we, len_we;
    logic [AW-1:0] pay_waddr, pay_raddr;
    logic [LW-1:0] len_wdata;
    logic          o_push;
    result_t       o_res;
    result_t       ofifo_reg [2];
    logic          o_wr_reg, o_rd_reg;
    logic [1:0]    o_cnt_reg;
    logic          room;
    logic          o_pop;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [4:0] occ(input logic [PW-1:0] t, input logic [PW-1:0] h);
        logic [PW:0] d;
        d = {1'b0, t} + (PW+1)'(QUEUE_SLOTS) - {1'b0, h};
        if (d >= (PW+1)'(QUEUE_SLOTS))
        begin
            d = d - (PW+1)'(QUEUE_SLOTS);
        end
        return 5'(d);
    endfunction

    assign room  = (o_cnt_reg != 2'd2);
    assign o_pop = pop && !empty;
    assign empty = (o_cnt_reg == 2'd0);
    assign res   = ofifo_reg[o_rd_reg];
    assign pay_raddr = AW'(head_reg) * AW'(PLEN) + ((k_reg == '0) ? '0 : AW'(k_reg - 1'b1));

    always_comb
    begin
        logic          starting;
        logic          drop;
        logic [LW-1:0] pc;
        logic          found;
        logic [TW-1:0] idx;
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        in_msg_next = in_msg_reg;
        drop_next   = drop_reg;
        pc_next     = pc_reg;
        seq_next    = seq_reg;
        fail_next   = fail_reg;
        tsrc_next   = tsrc_reg;
        tcnt_next   = tcnt_reg;
        total_next  = total_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        nb_next     = nb_reg;
        pay_we      = 1'b0;
        src_we      = 1'b0;
        len_we      = 1'b0;
        pay_waddr   = '0;
        len_wdata   = '0;
        cmd_take    = 1'b0;
        o_push      = 1'b0;
        o_res       = '0;
        o_res.out_last = 1'b1;
        o_res.status   = STATUS_OK;
        starting    = 1'b0;
        drop        = 1'b0;
        pc          = '0;
        found       = 1'b0;
        idx         = TW'(cmd.entry_index);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && room)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        CMD_PUSH:
                        begin
                            o_push   = 1'b1;
                            starting = !in_msg_reg;
                            drop     = starting ? (nxt(tail_reg) == head_reg) : drop_reg;
                            pc       = starting ? '0 : pc_reg;
                            src_we   = starting && !drop;
                            if (!drop && cmd.byte_valid && pc < LW'(PLEN))
                            begin
                                pay_we    = 1'b1;
                                pay_waddr = AW'(tail_reg) * AW'(PLEN) + AW'(pc);
                                pc        = pc + 1'b1;
                            end
                            o_res.status = drop ? STATUS_DROP : STATUS_OK;
                            if (cmd.last_byte)
                            begin
                                if (!drop)
                                begin
                                    len_we    = 1'b1;
                                    len_wdata = pc + 1'b1;
                                    tail_next = nxt(tail_reg);
                                end
                                in_msg_next = 1'b0;
                                drop_next   = 1'b0;
                                pc_next     = '0;
                            end
                            else
                            begin
                                in_msg_next = 1'b1;
                                drop_next   = drop;
                                pc_next     = pc;
                            end
                        end
                        CMD_EMIT:
                        begin
                            if (head_reg == tail_reg)
                            begin
                                o_push       = 1'b1;
                                o_res.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SRC;
                            end
                        end
                        CMD_SEND:
                        begin
                            o_push = 1'b1;
                            if (head_reg == tail_reg)
                            begin
                                o_res.status = STATUS_EMPTY;
                            end
                            else if (cmd.send_ok)
                            begin
                                fail_next = '0;
                                seq_next  = seq_reg + 1'b1;
                                head_next = nxt(head_reg);
                            end
                            else
                            begin
                                if (fail_reg != FAIL_MAX)
                                begin
                                    fail_next = fail_reg + 1'b1;
                                end
                                if (fail_next == FAIL_SOFT_LEVEL)
                                begin
                                    o_res.fail_action = ACTION_SOFT_RESET;
                                end
                                else if (fail_next == FAIL_HARD_LEVEL)
                                begin
                                    o_res.fail_action = ACTION_HARD_RESET;
                                end
                                else if (fail_next == FAIL_DUTY_LEVEL)
                                begin
                                    o_res.fail_action = ACTION_DUTY_CYCLE;
                                end
                                else
                                begin
                                    o_res.fail_action = ACTION_NONE;
                                end
                            end
                        end
                        default:
                        begin
                            o_push = 1'b1;
                            if (int'(cmd.entry_index) < TALLY_SLOTS)
                            begin
                                o_res.entry_source = tsrc_reg[idx];
                                o_res.entry_count  = tcnt_reg[idx];
                            end
                        end
                    endcase
                end
            end
            ST_SRC:
            begin
                if (src_q != NO_SOURCE)
                begin
                    for (int i = 0; i < TALLY_SLOTS; i++)
                    begin
                        if (!found && (tsrc_reg[i] == NO_SOURCE || tsrc_reg[i] == src_q))
                        begin
                            found        = 1'b1;
                            tcnt_next[i] = tcnt_reg[i] + 1'b1;
                            if (tsrc_reg[i] == NO_SOURCE)
                            begin
                                tsrc_next[i] = src_q;
                                total_next   = total_reg + 1'b1;
                            end
                        end
                    end
                end
                len_next   = (len_q > LW'(ENTRY_BYTES)) ? LW'(ENTRY_BYTES) : len_q;
                nb_next    = '0;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (room)
                begin
                    o_push         = 1'b1;
                    o_res.out_last = 1'b0;
                    o_res.out_byte = node_reg[8 * (NODE_BYTES - 1 - int'(nb_reg)) +: 8];
                    if (nb_reg == 3'(NODE_BYTES - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        nb_next = nb_reg + 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (room)
                begin
                    o_push = 1'b1;
                    if (k_reg == LW'(0))
                    begin
                        o_res.out_byte = src_q;
                    end
                    else if (k_reg == LW'(2))
                    begin
                        o_res.out_byte = seq_reg;
                    end
                    else
                    begin
                        o_res.out_byte = pay_q;
                    end
                    o_res.out_last = (k_reg + 1'b1 == len_reg);
                    if (o_res.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        o_res.occupancy    = occ(tail_next, head_next);
        o_res.modules_seen = 4'(total_next);
        o_res.seq_number   = seq_next;
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= cmd.data_byte;
        end
        if (src_we)
        begin
            src_mem[tail_reg] <= cmd.source_addr;
        end
        if (len_we)
        begin
            len_mem[tail_reg] <= len_wdata;
        end
        pay_q <= pay_mem[pay_raddr];
        src_q <= src_mem[head_reg];
        len_q <= len_mem[head_reg];
        if (o_push)
        begin
            ofifo_reg[o_wr_reg] <= o_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            in_msg_reg <= 1'b0;
            drop_reg   <= 1'b0;
            pc_reg     <= '0;
            seq_reg    <= '0;
            fail_reg   <= '0;
            total_reg  <= '0;
            k_reg      <= '0;
            len_reg    <= '0;
            nb_reg     <= '0;
            node_reg   <= '0;
            o_wr_reg   <= 1'b0;
            o_rd_reg   <= 1'b0;
            o_cnt_reg  <= 2'd0;
            for (int i = 0; i < TALLY_SLOTS; i++)
            begin
                tsrc_reg[i] <= '0;
                tcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            in_msg_reg <= in_msg_next;
            drop_reg   <= drop_next;
            pc_reg     <= pc_next;
            seq_reg    <= seq_next;
            fail_reg   <= fail_next;
            total_reg  <= total_next;
            k_reg      <= k_next;
            len_reg    <= len_next;
            nb_reg     <= nb_next;
            tsrc_reg   <= tsrc_next;
            tcnt_reg   <= tcnt_next;
            if (cfg_we)
            begin
                node_reg <= cfg_data;
            end
            if (o_push)
            begin
                o_wr_reg <= !o_wr_reg;
            end
            if (o_pop)
            begin
                o_rd_reg <= !o_rd_reg;
            end
            o_cnt_reg <= o_cnt_reg + 2'(o_push) - 2'(o_pop);
        end
    end

endmodule
